>>> rtl/skc_pkg.sv
// Shared types, constants and helpers of the solitaire keystream cipher.
`timescale 1ns / 1ps
package skc_pkg;

	typedef logic [4:0] card_t;
	typedef logic [4:0] idx_t;
	typedef logic [5:0] round_t;

	localparam int    DeckSize  = 28;
	localparam idx_t  LastIdx   = 5'd27;
	localparam card_t JokerA    = 5'd27;
	localparam card_t JokerB    = 5'd28;
	localparam card_t Alphabet  = 5'd26;
	localparam int    MaxRounds = 64;

	localparam logic OpLoad    = 1'b0;
	localparam logic OpEncrypt = 1'b1;

	typedef struct packed {
		logic  op;
		idx_t  position;
		card_t card;
		card_t letter;
	} req_beat_t;

	typedef struct packed {
		card_t cipher_letter;
		card_t key_value;
	} rsp_beat_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		card_t wdata;
		idx_t  raddr;
	} ram_req_t;

	// Values above 27 count as 27.
	function automatic idx_t clamp27(input card_t v);
		return (v > LastIdx) ? LastIdx : v;
	endfunction

	// Step one place down the deck with wraparound.
	function automatic idx_t inc28(input idx_t v);
		return (v == LastIdx) ? 5'd0 : v + 5'd1;
	endfunction

endpackage

>>> rtl/solitaire_keystream_cipher_top.sv
// Top level of the 28-card solitaire keystream cipher.
// One item is in work at a time. A load beat writes one deck card (a position above 27 writes
// nothing) and answers 0, 0. An encrypt beat runs deck rounds in two 28-entry memories; each
// round is five passes (a joker-27 scan, the joker-27 step, the joker-28 step, the triple cut
// and the count cut, one entry per cycle through the memory ports) and then a read of the
// output card, up to 64 rounds; it answers 0, 0 if no ordinary card appears. A finished
// result waits in the output register while the next beat is accepted; the block holds a new
// result back only while an earlier one is still stalled there.
`timescale 1ns / 1ps
module solitaire_keystream_cipher_top
	import skc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req_beat,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp_beat
);

	ram_req_t req_a, req_b;
	card_t    rd_a, rd_b;

	skc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_beat  (req_beat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_beat  (rsp_beat),
		.req_a     (req_a),
		.rd_a      (rd_a),
		.req_b     (req_b),
		.rd_b      (rd_b)
	);

	skc_deck_ram u_deck (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_a),
		.rdata  (rd_a)
	);

	skc_scratch_ram u_scratch (
		.clk   (clk),
		.req   (req_b),
		.rdata (rd_b)
	);

endmodule

>>> rtl/skc_deck_ram.sv
// Home deck memory: 28 cards, registered read, reads as the ordered deck until written.
`timescale 1ns / 1ps
module skc_deck_ram
	import skc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ram_req_t req,
	output card_t    rdata
);

	card_t             mem [DeckSize];
	logic [DeckSize-1:0] valid_q;
	card_t             rd_q;
	logic              rdv_q;
	idx_t              raddr_q;

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_q    <= mem[req.raddr];
		raddr_q <= req.raddr;
	end

	// Track entries that hold a written card
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_q   <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			rdv_q <= valid_q[req.raddr];
		end
	end

	assign rdata = rdv_q ? rd_q : (raddr_q + 5'd1);

endmodule

>>> rtl/skc_scratch_ram.sv
// Scratch deck memory: 28 cards, registered read, always filled before it is read.
`timescale 1ns / 1ps
module skc_scratch_ram
	import skc_pkg::*;
(
	input  logic     clk,
	input  ram_req_t req,
	output card_t    rdata
);

	card_t mem [DeckSize];
	card_t rd_q;

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_q <= mem[req.raddr];
	end

	assign rdata = rd_q;

endmodule

>>> rtl/skc_ctrl.sv
// Round sequencer: copy passes between the two deck memories and the response register.
`timescale 1ns / 1ps
module skc_ctrl
	import skc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req_beat,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp_beat,
	output ram_req_t  req_a,
	input  card_t     rd_a,
	output ram_req_t  req_b,
	input  card_t     rd_b
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_J27, S_J28, S_TRIP, S_CNT, S_KEY, S_RESP
	} state_t;

	state_t    state_q;
	logic [4:0] cnt_q;
	round_t    round_q;
	card_t     letter_q;
	rsp_beat_t res_q;
	rsp_beat_t rsp_beat_q;
	logic      rsp_valid_q;
	logic      f27_q, f28_q, fj_q;
	idx_t      i27_q, i28_q, top_j_q, bot_j_q;
	card_t     bottom_q, top_q;

	idx_t  j, widx, src, rsel;
	logic  do_wr;
	card_t wval;
	logic  [5:0] n1, mid, sum, md;
	idx_t  cc;
	card_t cipher;

	// Source index of each destination entry for the current pass
	always_comb begin
		j     = cnt_q;
		widx  = cnt_q - 5'd1;
		do_wr = (cnt_q != 5'd0);
		n1    = 6'd27 - {1'b0, bot_j_q};
		mid   = {1'b0, bot_j_q} - {1'b0, top_j_q} + 6'd1;
		cc    = clamp27(bottom_q);
		src   = j;
		case (state_q)
			S_J27: begin
				if (f27_q && j == i27_q) begin
					src = inc28(i27_q);
				end else if (f27_q && j == inc28(i27_q)) begin
					src = i27_q;
				end
			end
			S_J28: begin
				if (f28_q && j == i28_q) begin
					src = inc28(i28_q);
				end else if (f28_q && j == inc28(i28_q)) begin
					src = inc28(inc28(i28_q));
				end
			end
			S_TRIP: begin
				if (fj_q) begin
					if ({1'b0, j} < n1) begin
						src = bot_j_q + 5'd1 + j;
					end else if ({1'b0, j} < n1 + mid) begin
						src = 5'(6'(top_j_q) + 6'(j) - n1);
					end else begin
						src = 5'(6'(j) - n1 - mid);
					end
				end
			end
			S_CNT: begin
				if (cc != 5'd0 && cc < LastIdx) begin
					if (j < LastIdx - cc) begin
						src = cc + j;
					end else if (j < LastIdx) begin
						src = j + cc - LastIdx;
					end
				end
			end
			default: src = j;
		endcase
		rsel = (cnt_q == 5'(DeckSize)) ? 5'd0 : src;
	end

	// Drive memory ports
	always_comb begin
		req_a = '0;
		req_b = '0;
		wval  = rd_a;
		case (state_q)
			S_IDLE: begin
				req_a.we    = req_valid && req_beat.op == OpLoad && req_beat.position < LastIdx + 5'd1;
				req_a.waddr = req_beat.position;
				req_a.wdata = req_beat.card;
			end
			S_SCAN: req_a.raddr = rsel;
			S_J27, S_TRIP: begin
				req_a.raddr = rsel;
				wval        = rd_a;
				req_b.we    = do_wr;
				req_b.waddr = widx;
				req_b.wdata = wval;
			end
			S_J28, S_CNT: begin
				req_b.raddr = rsel;
				wval        = rd_b;
				if (state_q == S_J28 && f28_q && widx == inc28(inc28(i28_q))) begin
					wval = JokerB;
				end
				req_a.we    = do_wr;
				req_a.waddr = widx;
				req_a.wdata = wval;
			end
			S_KEY: req_a.raddr = clamp27(top_q);
			default: req_a.raddr = 5'd0;
		endcase
	end

	// Letter plus key, modulo 26, zero mapped to 26
	always_comb begin
		sum = {1'b0, rd_a} + {1'b0, letter_q};
		if (sum >= 6'd52) begin
			md = sum - 6'd52;
		end else if (sum >= 6'd26) begin
			md = sum - 6'd26;
		end else begin
			md = sum;
		end
		cipher = (md == 6'd0) ? Alphabet : md[4:0];
	end

	// Sequencer state, pass captures and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			round_q     <= '0;
			letter_q    <= '0;
			res_q       <= '0;
			rsp_beat_q  <= '0;
			rsp_valid_q <= 1'b0;
			f27_q       <= 1'b0;
			f28_q       <= 1'b0;
			fj_q        <= 1'b0;
			i27_q       <= '0;
			i28_q       <= '0;
			top_j_q     <= '0;
			bot_j_q     <= '0;
			bottom_q    <= '0;
			top_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q != S_IDLE && state_q != S_KEY && state_q != S_RESP) begin
				cnt_q <= (cnt_q == 5'(DeckSize)) ? 5'd0 : cnt_q + 5'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						letter_q <= req_beat.letter;
						cnt_q    <= '0;
						round_q  <= '0;
						res_q    <= '0;
						state_q  <= (req_beat.op == OpEncrypt) ? S_SCAN : S_RESP;
					end
				end
				S_SCAN: begin
					if (!do_wr) begin
						f27_q <= 1'b0;
					end else if (!f27_q && rd_a == JokerA) begin
						f27_q <= 1'b1;
						i27_q <= widx;
					end
					if (cnt_q == 5'(DeckSize)) state_q <= S_J27;
				end
				S_J27: begin
					if (!do_wr) begin
						f28_q <= 1'b0;
					end else if (!f28_q && wval == JokerB) begin
						f28_q <= 1'b1;
						i28_q <= widx;
					end
					if (cnt_q == 5'(DeckSize)) state_q <= S_J28;
				end
				S_J28: begin
					if (!do_wr) begin
						fj_q <= 1'b0;
					end else if (wval == JokerA || wval == JokerB) begin
						if (!fj_q) top_j_q <= widx;
						fj_q    <= 1'b1;
						bot_j_q <= widx;
					end
					if (cnt_q == 5'(DeckSize)) state_q <= S_TRIP;
				end
				S_TRIP: begin
					if (do_wr && widx == LastIdx) bottom_q <= wval;
					if (cnt_q == 5'(DeckSize)) state_q <= S_CNT;
				end
				S_CNT: begin
					if (cnt_q == 5'd1) top_q <= wval;
					if (cnt_q == 5'(DeckSize)) state_q <= S_KEY;
				end
				S_KEY: begin
					if (cnt_q == 5'd0) begin
						cnt_q <= 5'd1;
					end else begin
						cnt_q <= 5'd0;
						if (rd_a >= 5'd1 && rd_a <= Alphabet) begin
							res_q.key_value     <= rd_a;
							res_q.cipher_letter <= cipher;
							state_q             <= S_RESP;
						end else if (round_q == 6'(MaxRounds - 1)) begin
							res_q   <= '0;
							state_q <= S_RESP;
						end else begin
							round_q <= round_q + 6'd1;
							state_q <= S_SCAN;
						end
					end
				end
				S_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						rsp_beat_q  <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_beat_q;

endmodule

>>> rtl/skc_checker.sv
// Port-level checks of the solitaire keystream cipher, bound to the top level.
`timescale 1ns / 1ps
module skc_checker
	import skc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input req_beat_t req_beat,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_beat_t rsp_beat
);

	// Hold a stalled result beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
		else $error("stalled result beat changed");

	// Busy right after an accepted beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("accepted a second beat while busy");

	// Key and letter are both zero or both set
	a_zero_pair: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_beat.cipher_letter == 5'd0) == (rsp_beat.key_value == 5'd0)))
		else $error("key and cipher letter disagree on zero");

	// Result values stay in the alphabet
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_beat.cipher_letter <= Alphabet && rsp_beat.key_value <= Alphabet)
		else $error("result out of range");

endmodule

bind solitaire_keystream_cipher_top skc_checker u_skc_checker (.*);

>>> dv/tb_top.sv
// Testbench for the solitaire keystream cipher: scoreboard, stimulus and checking.
`timescale 1ns / 1ps
module tb_top;
	import skc_pkg::*;

	// Keeps a copy of the deck, predicts each answer and checks the answers in order.
	class cipher_scoreboard;
		card_t     deck[DeckSize];
		rsp_beat_t pending_q[$];
		int        errors;
		int        loads;
		int        encrypts;
		int        exhausted;

		function new();
			for (int i = 0; i < DeckSize; i++) deck[i] = card_t'(i + 1);
		endfunction

		function int first_of(card_t v);
			for (int i = 0; i < DeckSize; i++) if (deck[i] == v) return i;
			return DeckSize;
		endfunction

		// Run one deck round and return the output card.
		function card_t shuffle_round();
			card_t tmp[DeckSize];
			card_t t;
			int    i, a, b, n, top, bot, c;
			i = first_of(JokerA);
			if (i < DeckSize) begin
				a = (i + 1) % DeckSize;
				t = deck[i];
				deck[i] = deck[a];
				deck[a] = t;
			end
			i = first_of(JokerB);
			if (i < DeckSize) begin
				a = (i + 1) % DeckSize;
				b = (i + 2) % DeckSize;
				deck[i] = deck[a];
				deck[a] = deck[b];
				deck[b] = JokerB;
			end
			// triple cut around the outermost jokers
			top = DeckSize;
			bot = 0;
			for (i = 0; i < DeckSize; i++)
				if (deck[i] == JokerA || deck[i] == JokerB) begin
					if (top == DeckSize) top = i;
					bot = i;
				end
			if (top != DeckSize) begin
				n = 0;
				for (i = bot + 1; i < DeckSize; i++) tmp[n++] = deck[i];
				for (i = top; i <= bot; i++) tmp[n++] = deck[i];
				for (i = 0; i < top; i++) tmp[n++] = deck[i];
				deck = tmp;
			end
			// count cut by the bottom card
			c = (deck[27] > 27) ? 27 : deck[27];
			if (c != 0 && c < 27) begin
				for (i = 0; i + c < 27; i++) tmp[i] = deck[c + i];
				for (i = 0; i < c; i++) tmp[27 - c + i] = deck[i];
				tmp[27] = deck[27];
				deck = tmp;
			end
			return deck[(deck[0] > 27) ? 27 : deck[0]];
		endfunction

		function void note_req(req_beat_t b);
			rsp_beat_t r;
			card_t     k;
			int        cl;
			r = '0;
			if (b.op == OpLoad) begin
				loads++;
				if (b.position < DeckSize) deck[b.position] = b.card;
			end else begin
				encrypts++;
				for (int rnd = 0; rnd < MaxRounds; rnd++) begin
					k = shuffle_round();
					if (k >= 1 && k <= Alphabet) begin
						cl = (int'(k) + int'(b.letter)) % 26;
						if (cl == 0) cl = 26;
						r.cipher_letter = card_t'(cl);
						r.key_value = k;
						break;
					end
				end
				if (r.key_value == 0) exhausted++;
			end
			pending_q.push_back(r);
		endfunction

		function void check_rsp(rsp_beat_t r);
			rsp_beat_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected answer cipher %0d key %0d", $time,
					r.cipher_letter, r.key_value);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (r.cipher_letter !== e.cipher_letter) begin
				$display("%0t: cipher_letter expected %0d actual %0d", $time,
					e.cipher_letter, r.cipher_letter);
				errors++;
			end
			if (r.key_value !== e.key_value) begin
				$display("%0t: key_value expected %0d actual %0d", $time,
					e.key_value, r.key_value);
				errors++;
			end
		endfunction
	endclass

	localparam longint CycleLimit = 64'd60_000_000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_beat_t req_beat = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp_beat;

	cipher_scoreboard sb = new();
	longint           cycles = 0;
	int               burst_left = 0;
	int               stall_pct = 0;

	solitaire_keystream_cipher_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_beat (req_beat),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_beat (rsp_beat)
	);

	always #4 clk = ~clk;

	// Count cycles and give up on a hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Check answers and stall at a random rate that is redrawn from four levels.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_rsp(rsp_beat);
		if (cycles % 256 == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 20;
				2: stall_pct <= 60;
				default: stall_pct <= 90;
			endcase
		end
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Present one beat and hold it until accepted; sometimes idle between bursts.
	task automatic send(input req_beat_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_beat  <= b;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_req(b);
		burst_left--;
	endtask

	task automatic load(input int pos, input int c);
		req_beat_t b;
		b = '0;
		b.op = OpLoad;
		b.position = idx_t'(pos);
		b.card = card_t'(c);
		b.letter = card_t'($urandom_range(0, 31));
		send(b);
	endtask

	task automatic encrypt(input int ltr);
		req_beat_t b;
		b = '0;
		b.op = OpEncrypt;
		b.position = idx_t'($urandom_range(0, 31));
		b.card = card_t'($urandom_range(0, 31));
		b.letter = card_t'(ltr);
		send(b);
	endtask

	// Load a fresh random permutation of all 28 cards.
	task automatic load_shuffled_deck();
		int perm[DeckSize];
		int j, t;
		for (int i = 0; i < DeckSize; i++) perm[i] = i + 1;
		for (int i = DeckSize - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int i = 0; i < DeckSize; i++) load(i, perm[i]);
	endtask

	initial begin
		int sent, pick, pa, pb, ca, cb;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset deck, letter extremes, jokers at the bottom wrapping
		encrypt(1);
		encrypt(26);
		encrypt(0);
		encrypt(31);
		load(0, 28);
		load(26, 1);
		load(27, 0);
		load(31, 5);
		load(28, 31);
		encrypt(13);
		encrypt(7);
		// deck with no ordinary card hits the round limit
		for (int i = 0; i < DeckSize; i++) load(i, 0);
		encrypt(9);
		for (int i = 0; i < DeckSize; i++) load(i, i + 1);
		sent = 0;

		// random: mostly encrypts on a well-formed deck, swaps and some noise
		while (sent < 1600) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				encrypt(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
					: $urandom_range(1, 26));
				sent++;
			end else if (pick < 85) begin
				pa = $urandom_range(0, 27);
				pb = $urandom_range(0, 27);
				ca = sb.deck[pa];
				cb = sb.deck[pb];
				load(pa, cb);
				load(pb, ca);
				sent += 2;
			end else if (pick < 91) begin
				load($urandom_range(28, 31), $urandom_range(0, 31));
				sent++;
			end else if (pick < 96) begin
				load($urandom_range(0, 27), $urandom_range(0, 31));
				sent++;
			end else begin
				load_shuffled_deck();
				sent += DeckSize;
			end
		end

		req_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("Covered %0d loads and %0d encrypts, %0d of them at the round limit.",
			sb.loads, sb.encrypts, sb.exhausted);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/skc_pkg.sv
rtl/skc_deck_ram.sv
rtl/skc_scratch_ram.sv
rtl/skc_ctrl.sv
rtl/solitaire_keystream_cipher_top.sv
rtl/skc_checker.sv
dv/tb_top.sv
